[rtl/core/dlte_pkg.sv]
`timescale 1ns / 1ps

package dlte_pkg;

	// default store geometry
	localparam int DEF_MAX_INPUTS = 16;
	localparam int DEF_MAX_UNITS  = 16;

	// register reset values
	localparam logic [15:0] LR_RESET    = 16'd655;
	localparam logic [4:0]  COUNT_RESET = 5'd16;

	// datapath widths
	localparam int ACC_W  = 38;
	localparam int GRAD_W = 40;

	// input modes
	localparam logic [2:0] MODE_LOAD_X = 3'd0;
	localparam logic [2:0] MODE_LOAD_D = 3'd1;
	localparam logic [2:0] MODE_FWD    = 3'd2;
	localparam logic [2:0] MODE_BWD    = 3'd3;
	localparam logic [2:0] MODE_APPLY  = 3'd4;
	localparam logic [2:0] MODE_WR_W   = 3'd5;
	localparam logic [2:0] MODE_WR_B   = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_ACT   = 2'd1;
	localparam logic [1:0] KIND_DERIV = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_LR = 2'd0;
	localparam logic [1:0] REG_NI = 2'd1;
	localparam logic [1:0] REG_NU = 2'd2;

	typedef enum logic [1:0] {
		OP_ACK,
		OP_FWD,
		OP_BWD,
		OP_APPLY
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN
	} state_t;

	localparam logic signed [40:0] GRAD_MAX = 41'sd549755813887;
	localparam logic signed [40:0] GRAD_MIN = -41'sd549755813888;

	// round half up to q4.12 and saturate
	function automatic logic signed [15:0] round_sat16(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] r;
		r = (a + ACC_W'(2048)) >>> 12;
		if (r > 32767)
			round_sat16 = 16'sh7fff;
		else if (r < -32768)
			round_sat16 = -16'sh8000;
		else
			round_sat16 = r[15:0];
	endfunction

	// saturate a grown gradient sum to 40 bits
	function automatic logic signed [GRAD_W-1:0] sat40(input logic signed [40:0] a);
		if (a > GRAD_MAX)
			sat40 = GRAD_MAX[GRAD_W-1:0];
		else if (a < GRAD_MIN)
			sat40 = GRAD_MIN[GRAD_W-1:0];
		else
			sat40 = a[GRAD_W-1:0];
	endfunction

	// saturate a weight difference to q4.12
	function automatic logic signed [15:0] sat16(input logic signed [32:0] a);
		if (a > 33'sd32767)
			sat16 = 16'sh7fff;
		else if (a < -33'sd32768)
			sat16 = -16'sh8000;
		else
			sat16 = a[15:0];
	endfunction

endpackage

[rtl/core/dense_layer_train_engine.sv]
`timescale 1ns / 1ps
// throughput: one item at a time, one multiply-accumulate per cycle through the
// weight and gradient memories while the output is not stalled; the next word is
// taken once the pipeline drains
// reset: asynchronous, active low; after reset a clearing pass zeroes all stores
// before the first word is taken
module dense_layer_train_engine #(
	parameter int MAX_INPUTS = dlte_pkg::DEF_MAX_INPUTS,
	parameter int MAX_UNITS  = dlte_pkg::DEF_MAX_UNITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // row[3:0], col[7:4], value[23:8]
	input  logic [2:0]  s_axis_tuser,  // mode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // index[3:0], result_value[19:4], zero[23:20]
	output logic [1:0]  m_axis_tuser,  // kind[1:0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int MAXD  = (MAX_UNITS > MAX_INPUTS) ? MAX_UNITS : MAX_INPUTS;
	localparam int DW    = $clog2(MAXD + 2);
	localparam int AI    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int AU    = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam int NW    = MAX_UNITS * MAX_INPUTS;
	localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
	localparam int MW    = $clog2(NW + MAXD + 2);
	localparam int LIM_I = (MAX_INPUTS < 16) ? MAX_INPUTS : 16;
	localparam int LIM_U = (MAX_UNITS < 16) ? MAX_UNITS : 16;
	localparam int ACC_W = dlte_pkg::ACC_W;
	localparam int GW    = dlte_pkg::GRAD_W;

	// stores
	logic signed [15:0]   x_mem  [MAX_INPUTS];
	logic signed [15:0]   d_mem  [MAX_UNITS];
	logic signed [15:0]   w_mem  [NW];
	logic signed [15:0]   b_mem  [MAX_UNITS];
	logic signed [GW-1:0] g_mem  [NW];
	logic signed [GW-1:0] gb_mem [MAX_UNITS];

	// input word fields
	logic [3:0]         in_row, in_col;
	logic signed [15:0] in_value;
	logic [2:0]         in_mode;
	logic [7:0]         row_e, col_e;
	logic               accept;

	assign in_row   = s_axis_tdata[3:0];
	assign in_col   = s_axis_tdata[7:4];
	assign in_value = s_axis_tdata[23:8];
	assign in_mode  = s_axis_tuser;
	assign row_e    = 8'(in_row);
	assign col_e    = 8'(in_col);
	assign accept   = s_axis_tvalid && s_axis_tready;

	// configuration registers
	logic [15:0] lr_q;
	logic [4:0]  ni_q, nu_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= dlte_pkg::LR_RESET;
			ni_q <= dlte_pkg::COUNT_RESET;
			nu_q <= dlte_pkg::COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				dlte_pkg::REG_LR: lr_q <= cfg_data;
				dlte_pkg::REG_NI: ni_q <= cfg_data[4:0];
				dlte_pkg::REG_NU: nu_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// clamped active counts
	logic [4:0]    ni_c, nu_c;
	logic [DW-1:0] ni_d, nu_d;

	always_comb begin
		ni_c = (ni_q == 5'd0) ? 5'd1 : ((ni_q > 5'(LIM_I)) ? 5'(LIM_I) : ni_q);
		nu_c = (nu_q == 5'd0) ? 5'd1 : ((nu_q > 5'(LIM_U)) ? 5'(LIM_U) : nu_q);
		ni_d = DW'(ni_c);
		nu_d = DW'(nu_c);
	end

	// sequencer state
	dlte_pkg::state_t state_q, state_n;
	dlte_pkg::op_t    op_q;
	logic [DW-1:0]    i_q, j_q;
	logic [MW-1:0]    mul_q;
	logic [AW-1:0]    clr_q;
	logic [3:0]       ack_idx_q;
	logic             clr_done;

	logic v_s1, v_s2, v_s3;
	logic out_valid_q;
	logic adv;

	// issue decode signals
	logic          iss;
	logic          iss_first, iss_emit, iss_done, iss_bias, iss_gbw;
	logic [3:0]    iss_idx;
	logic [DW-1:0] jend;
	logic          j_end, i_end;
	logic [AW-1:0] wa0;

	assign adv      = !out_valid_q || m_axis_tready;
	assign clr_done = (clr_q == AW'(NW - 1));

	assign s_axis_tready = (state_q == dlte_pkg::ST_IDLE) && !v_s1 && !v_s2 && !v_s3;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			dlte_pkg::ST_CLEAR: begin
				if (clr_done)
					state_n = dlte_pkg::ST_IDLE;
			end
			dlte_pkg::ST_IDLE: begin
				if (accept && in_mode <= dlte_pkg::MODE_WR_B)
					state_n = dlte_pkg::ST_RUN;
			end
			dlte_pkg::ST_RUN: begin
				if (adv && iss_done)
					state_n = dlte_pkg::ST_IDLE;
			end
			default: state_n = dlte_pkg::ST_IDLE;
		endcase
	end

	// issue decode
	always_comb begin
		iss       = (state_q == dlte_pkg::ST_RUN) && adv;
		jend      = (op_q == dlte_pkg::OP_APPLY) ? DW'(MAX_INPUTS) : ni_d - 1'b1;
		j_end     = (j_q == jend);
		i_end     = (i_q == nu_d - 1'b1);
		iss_first = 1'b0;
		iss_emit  = 1'b0;
		iss_done  = 1'b0;
		iss_bias  = 1'b0;
		iss_gbw   = 1'b0;
		iss_idx   = 4'd0;
		case (op_q)
			dlte_pkg::OP_FWD: begin
				iss_first = (j_q == '0);
				iss_emit  = j_end;
				iss_done  = j_end && i_end;
				iss_idx   = 4'(i_q);
			end
			dlte_pkg::OP_BWD: begin
				iss_first = (i_q == '0);
				iss_emit  = i_end;
				iss_done  = i_end && (j_q == ni_d - 1'b1);
				iss_gbw   = (j_q == '0);
				iss_idx   = 4'(j_q);
			end
			dlte_pkg::OP_APPLY: begin
				iss_bias  = (j_q == DW'(MAX_INPUTS));
				iss_done  = iss_bias && (i_q == DW'(MAX_UNITS - 1));
				iss_emit  = iss_done;
			end
			dlte_pkg::OP_ACK: begin
				iss_emit  = 1'b1;
				iss_done  = 1'b1;
				iss_idx   = ack_idx_q;
			end
			default: ;
		endcase
		wa0 = iss_bias ? '0 : AW'(mul_q + MW'(j_q));
	end

	// sequencer registers and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dlte_pkg::ST_CLEAR;
			op_q      <= dlte_pkg::OP_ACK;
			i_q       <= '0;
			j_q       <= '0;
			mul_q     <= '0;
			clr_q     <= '0;
			ack_idx_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == dlte_pkg::ST_CLEAR && !clr_done)
				clr_q <= clr_q + 1'b1;
			if (accept) begin
				i_q       <= '0;
				j_q       <= '0;
				mul_q     <= '0;
				ack_idx_q <= (in_mode == dlte_pkg::MODE_LOAD_X) ? in_col : in_row;
				case (in_mode)
					dlte_pkg::MODE_FWD:   op_q <= dlte_pkg::OP_FWD;
					dlte_pkg::MODE_BWD:   op_q <= dlte_pkg::OP_BWD;
					dlte_pkg::MODE_APPLY: op_q <= dlte_pkg::OP_APPLY;
					default:              op_q <= dlte_pkg::OP_ACK;
				endcase
			end else if (iss) begin
				case (op_q)
					dlte_pkg::OP_FWD, dlte_pkg::OP_APPLY: begin
						if (j_end) begin
							j_q   <= '0;
							i_q   <= i_q + 1'b1;
							mul_q <= mul_q + MW'(MAX_INPUTS);
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					dlte_pkg::OP_BWD: begin
						if (i_end) begin
							i_q   <= '0;
							mul_q <= '0;
							j_q   <= j_q + 1'b1;
						end else begin
							i_q   <= i_q + 1'b1;
							mul_q <= mul_q + MW'(MAX_INPUTS);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// pipeline control
	dlte_pkg::op_t op_s1, op_s2, op_s3;
	logic          first_s1, first_s2;
	logic          emit_s1, emit_s2, emit_s3;
	logic          done_s1, done_s2, done_s3;
	logic          bias_s1, bias_s2, bias_s3;
	logic          gbw_s1, gbw_s2;
	logic [3:0]    idx_s1, idx_s2, idx_s3;
	logic [AU-1:0] ua_s1, ua_s2, ua_s3;
	logic [AW-1:0] wa_s1, wa_s2, wa_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= iss;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= op_q;
			first_s1 <= iss_first;
			emit_s1  <= iss_emit;
			done_s1  <= iss_done;
			bias_s1  <= iss_bias;
			gbw_s1   <= iss_gbw;
			idx_s1   <= iss_idx;
			ua_s1    <= i_q[AU-1:0];
			wa_s1    <= wa0;
			op_s2    <= op_s1;
			first_s2 <= first_s1;
			emit_s2  <= emit_s1;
			done_s2  <= done_s1;
			bias_s2  <= bias_s1;
			gbw_s2   <= gbw_s1;
			idx_s2   <= idx_s1;
			ua_s2    <= ua_s1;
			wa_s2    <= wa_s1;
			op_s3    <= op_s2;
			emit_s3  <= emit_s2;
			done_s3  <= done_s2;
			bias_s3  <= bias_s2;
			idx_s3   <= idx_s2;
			ua_s3    <= ua_s2;
			wa_s3    <= wa_s2;
		end
	end

	// write-back values from later stages
	logic signed [GW-1:0] g_new, gb_new;
	logic signed [15:0]   w_new;
	logic                 in_clear;

	assign in_clear = (state_q == dlte_pkg::ST_CLEAR);

	// input vector memory
	logic signed [15:0] x_s1;

	always_ff @(posedge clk) begin
		if (in_clear) begin
			if (32'(clr_q) < MAX_INPUTS)
				x_mem[clr_q[AI-1:0]] <= '0;
		end else if (accept && in_mode == dlte_pkg::MODE_LOAD_X && 32'(in_col) < MAX_INPUTS) begin
			x_mem[col_e[AI-1:0]] <= in_value;
		end
		if (adv)
			x_s1 <= x_mem[j_q[AI-1:0]];
	end

	// output derivative memory
	logic signed [15:0] d_s1;

	always_ff @(posedge clk) begin
		if (in_clear) begin
			if (32'(clr_q) < MAX_UNITS)
				d_mem[clr_q[AU-1:0]] <= '0;
		end else if (accept && in_mode == dlte_pkg::MODE_LOAD_D && 32'(in_row) < MAX_UNITS) begin
			d_mem[row_e[AU-1:0]] <= in_value;
		end
		if (adv)
			d_s1 <= d_mem[i_q[AU-1:0]];
	end

	// weight memory
	logic signed [15:0] w_s1;

	always_ff @(posedge clk) begin
		if (in_clear) begin
			w_mem[clr_q] <= '0;
		end else if (accept && in_mode == dlte_pkg::MODE_WR_W && 32'(in_row) < MAX_UNITS
				&& 32'(in_col) < MAX_INPUTS) begin
			w_mem[AW'(32'(row_e) * MAX_INPUTS + 32'(col_e))] <= in_value;
		end else if (adv && v_s3 && op_s3 == dlte_pkg::OP_APPLY && !bias_s3) begin
			w_mem[wa_s3] <= w_new;
		end
		if (adv)
			w_s1 <= w_mem[wa0];
	end

	// bias memory
	logic signed [15:0] b_s1;

	always_ff @(posedge clk) begin
		if (in_clear) begin
			if (32'(clr_q) < MAX_UNITS)
				b_mem[clr_q[AU-1:0]] <= '0;
		end else if (accept && in_mode == dlte_pkg::MODE_WR_B && 32'(in_row) < MAX_UNITS) begin
			b_mem[row_e[AU-1:0]] <= in_value;
		end else if (adv && v_s3 && op_s3 == dlte_pkg::OP_APPLY && bias_s3) begin
			b_mem[ua_s3] <= w_new;
		end
		if (adv)
			b_s1 <= b_mem[i_q[AU-1:0]];
	end

	// weight gradient memory, cleared as apply reads it
	logic signed [GW-1:0] g_s1;

	always_ff @(posedge clk) begin
		if (in_clear) begin
			g_mem[clr_q] <= '0;
		end else if (iss && op_q == dlte_pkg::OP_APPLY && !iss_bias) begin
			g_mem[wa0] <= '0;
		end else if (adv && v_s2 && op_s2 == dlte_pkg::OP_BWD) begin
			g_mem[wa_s2] <= g_new;
		end
		if (adv)
			g_s1 <= g_mem[wa0];
	end

	// bias gradient memory
	logic signed [GW-1:0] gb_s1;

	always_ff @(posedge clk) begin
		if (in_clear) begin
			if (32'(clr_q) < MAX_UNITS)
				gb_mem[clr_q[AU-1:0]] <= '0;
		end else if (iss && op_q == dlte_pkg::OP_APPLY && iss_bias) begin
			gb_mem[i_q[AU-1:0]] <= '0;
		end else if (adv && v_s2 && op_s2 == dlte_pkg::OP_BWD && gbw_s2) begin
			gb_mem[ua_s2] <= gb_new;
		end
		if (adv)
			gb_s1 <= gb_mem[i_q[AU-1:0]];
	end

	// stage 1: two shared multipliers
	logic signed [GW-1:0] gsel;
	logic signed [15:0]   wsel;
	logic signed [20:0]   ma_a, mb_a;
	logic signed [17:0]   ma_b, mb_b, lr_s;
	logic signed [38:0]   pa_n, pb_n;

	always_comb begin
		gsel = bias_s1 ? gb_s1 : g_s1;
		wsel = bias_s1 ? b_s1 : w_s1;
		lr_s = $signed({2'b00, lr_q});
		ma_a = '0;
		ma_b = '0;
		mb_a = '0;
		mb_b = '0;
		case (op_s1)
			dlte_pkg::OP_FWD: begin
				ma_a = 21'(x_s1);
				ma_b = 18'(w_s1);
			end
			dlte_pkg::OP_BWD: begin
				ma_a = 21'(x_s1);
				ma_b = 18'(d_s1);
				mb_a = 21'(w_s1);
				mb_b = 18'(d_s1);
			end
			dlte_pkg::OP_APPLY: begin
				// gradient split into signed high and unsigned low halves
				ma_a = 21'($signed(gsel[GW-1:20]));
				ma_b = lr_s;
				mb_a = $signed({1'b0, gsel[19:0]});
				mb_b = lr_s;
			end
			default: ;
		endcase
		pa_n = ma_a * ma_b;
		pb_n = mb_a * mb_b;
	end

	logic signed [38:0]   pa_s2, pb_s2;
	logic signed [GW-1:0] g_s2, gb_s2;
	logic signed [15:0]   b_s2, d_s2, w_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2 <= pa_n;
			pb_s2 <= pb_n;
			g_s2  <= gsel;
			gb_s2 <= gb_s1;
			b_s2  <= b_s1;
			d_s2  <= d_s1;
			w_s2  <= wsel;
		end
	end

	// stage 2: accumulate, gradient update, apply step
	logic signed [ACC_W-1:0] acc_q, acc_base, acc_n;
	logic signed [40:0]      g_sum, gb_sum;
	logic signed [59:0]      step_sum;
	logic signed [31:0]      step_n;

	always_comb begin
		if (!first_s2)
			acc_base = acc_q;
		else if (op_s2 == dlte_pkg::OP_FWD)
			acc_base = ACC_W'(b_s2) <<< 12;
		else
			acc_base = '0;
		acc_n    = acc_base + ACC_W'((op_s2 == dlte_pkg::OP_BWD) ? pb_s2 : pa_s2);
		g_sum    = 41'(g_s2) + 41'(pa_s2);
		gb_sum   = 41'(gb_s2) + (41'(d_s2) <<< 12);
		g_new    = dlte_pkg::sat40(g_sum);
		gb_new   = dlte_pkg::sat40(gb_sum);
		step_sum = (60'(pa_s2) <<< 20) + 60'(pb_s2) + 60'sd134217728;
		step_n   = 32'(step_sum >>> 28);
	end

	logic signed [31:0] step_s3;
	logic signed [15:0] w_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s2 && (op_s2 == dlte_pkg::OP_FWD || op_s2 == dlte_pkg::OP_BWD))
				acc_q <= acc_n;
			step_s3 <= step_n;
			w_s3    <= w_s2;
		end
	end

	// stage 3: new weight and rounded result
	logic signed [15:0] res_val;
	logic [1:0]         res_kind;

	always_comb begin
		w_new    = dlte_pkg::sat16(33'(w_s3) - 33'(step_s3));
		res_val  = '0;
		res_kind = dlte_pkg::KIND_ACK;
		case (op_s3)
			dlte_pkg::OP_FWD: begin
				res_kind = dlte_pkg::KIND_ACT;
				res_val  = dlte_pkg::round_sat16(acc_q);
			end
			dlte_pkg::OP_BWD: begin
				res_kind = dlte_pkg::KIND_DERIV;
				res_val  = dlte_pkg::round_sat16(acc_q);
			end
			dlte_pkg::OP_APPLY: res_kind = dlte_pkg::KIND_DONE;
			default: ;
		endcase
	end

	// output word register
	logic [23:0] out_data_q;
	logic [1:0]  out_kind_q;
	logic        out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s3 && emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3 && emit_s3) begin
			out_data_q <= {4'b0000, res_val, idx_s3};
			out_kind_q <= res_kind;
			out_last_q <= done_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// checks
	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("word taken with pipeline busy");

	a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlte_pkg::ST_CLEAR) |=> !v_s1)
		else $error("pipeline active during clearing pass");

	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3 && emit_s3) |=> m_axis_tvalid)
		else $error("result lost at output register");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && v_s3) |=> v_s3)
		else $error("stage advanced during stall");

endmodule
